/* design/gmb_pkg.sv */
// Package for the grid maze backtracker: sizes, register indexes, direction
// orderings and the command/status types between controller and datapath.
// No dependencies.
package gmb_pkg;
   localparam int MaxWidth  = 64;
   localparam int MaxHeight = 64;
   localparam int XW        = $clog2(MaxWidth);
   localparam int YW        = $clog2(MaxHeight);
   localparam int AW        = XW + YW;
   localparam int DW        = AW + 1;

   localparam logic [1:0] CSR_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_START_X = 2'd2;
   localparam logic [1:0] CSR_START_Y = 2'd3;

   typedef enum logic [1:0] {DIR_N = 2'd0, DIR_E = 2'd1, DIR_S = 2'd2, DIR_W = 2'd3} dir_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_INIT, ST_TOP, ST_TRY, ST_CHECK, ST_CARVE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic init;
      logic load_top;
      logic try_dir;
      logic pop;
      logic carve;
      logic emit_done;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic started;
      logic empty;
      logic exhausted;
      logic nb_ok;
   } sts_type;

   function automatic logic [1:0] order_dir(input logic [4:0] perm, input logic [1:0] k);
      logic [7:0] row;
      case (perm)
         5'd0:  row = 8'b11_10_01_00;
         5'd1:  row = 8'b10_11_01_00;
         5'd2:  row = 8'b11_01_10_00;
         5'd3:  row = 8'b01_11_10_00;
         5'd4:  row = 8'b10_01_11_00;
         5'd5:  row = 8'b01_10_11_00;
         5'd6:  row = 8'b11_10_00_01;
         5'd7:  row = 8'b10_11_00_01;
         5'd8:  row = 8'b11_00_10_01;
         5'd9:  row = 8'b00_11_10_01;
         5'd10: row = 8'b10_00_11_01;
         5'd11: row = 8'b00_10_11_01;
         5'd12: row = 8'b11_01_00_10;
         5'd13: row = 8'b01_11_00_10;
         5'd14: row = 8'b11_00_01_10;
         5'd15: row = 8'b00_11_01_10;
         5'd16: row = 8'b01_00_11_10;
         5'd17: row = 8'b00_01_11_10;
         5'd18: row = 8'b10_01_00_11;
         5'd19: row = 8'b01_10_00_11;
         5'd20: row = 8'b10_00_01_11;
         5'd21: row = 8'b00_10_01_11;
         5'd22: row = 8'b01_00_10_11;
         5'd23: row = 8'b00_01_10_11;
         default: row = 8'b11_10_01_00;
      endcase
      return row[2*k +: 2];
   endfunction
endpackage

/* design/gmb_ctrl.sv */
// Controller state machine for the grid maze backtracker.
// Depends on gmb_pkg; drives commands to gmb_datapath.
module gmb_ctrl import gmb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sts.clear_last) state_in = ST_IDLE;
         ST_IDLE:  if (start) state_in = sts.started ? ST_TOP : ST_INIT;
         ST_INIT:  state_in = ST_TOP;
         ST_TOP:   state_in = sts.empty ? ST_IDLE : ST_TRY;
         ST_TRY:   state_in = sts.exhausted ? ST_TOP : ST_CHECK;
         ST_CHECK: state_in = sts.nb_ok ? ST_CARVE : ST_TRY;
         ST_CARVE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_INIT:  cmd.init = 1'b1;
         ST_TOP: begin
            cmd.load_top = !sts.empty;
            cmd.emit_done = sts.empty;
         end
         ST_TRY: begin
            cmd.pop = sts.exhausted;
            cmd.try_dir = !sts.exhausted;
         end
         ST_CARVE: cmd.carve = 1'b1;
         default: ;
      endcase
   end

   a_done_only_top: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_done |-> state_ff == ST_TOP) else $error("done outside top");
   a_carve_then_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CARVE |=> state_ff == ST_IDLE) else $error("carve exit");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
endmodule

/* design/gmb_datapath.sv */
// Datapath for the grid maze backtracker: cell memory, path stack, top-entry
// registers and result registers. Depends on gmb_pkg; driven by gmb_ctrl.
module gmb_datapath import gmb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic          accept,
   input  logic [4:0]    perm_index,
   input  logic          cfg_we,
   input  logic [1:0]    cfg_index,
   input  logic [6:0]    cfg_data,
   output logic          rsp_valid,
   output logic [5:0]    rsp_cell_x,
   output logic [5:0]    rsp_cell_y,
   output logic [1:0]    rsp_direction,
   output logic          rsp_done_res
);
   localparam logic [6:0] MaxW7 = 7'(MaxWidth);
   localparam logic [6:0] MaxH7 = 7'(MaxHeight);

   logic [6:0] width_ff, height_ff;
   logic [5:0] sx_ff, sy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 7'd16; height_ff <= 7'd16; sx_ff <= '0; sy_ff <= '0;
      end else if (cfg_we) begin
         case (cfg_index)
            CSR_WIDTH:   width_ff <= cfg_data;
            CSR_HEIGHT:  height_ff <= cfg_data;
            CSR_START_X: sx_ff <= cfg_data[5:0];
            CSR_START_Y: sy_ff <= cfg_data[5:0];
            default: ;
         endcase
      end
   end

   logic [6:0] ew, eh;
   assign ew = (width_ff == '0) ? 7'd1 : (width_ff > MaxW7 ? MaxW7 : width_ff);
   assign eh = (height_ff == '0) ? 7'd1 : (height_ff > MaxH7 ? MaxH7 : height_ff);

   // cell memory holds visited bits; walls are reported, never read back
   logic             visit_mem [2**AW];
   logic [XW+YW-1:0] stack_mem [2**AW];
   logic [2:0]       tried_mem [2**AW];
   logic [4:0]       perm_mem [2**AW];
   logic [AW:0]      clr_ff;
   logic             started_ff;
   logic [4:0]       perm_ff;
   logic             psel_ff;
   logic [DW-1:0]    depth_ff;
   logic [XW-1:0]    tx_ff;
   logic [YW-1:0]    ty_ff;
   logic [4:0]       tp_ff;
   logic [2:0]       tried_ff;
   logic [1:0]       dir_ff;
   logic [XW-1:0]    nx_ff;
   logic [YW-1:0]    ny_ff;
   logic             inb_ff;
   logic             vis_rd_ff;

   assign sts.clear_last = clr_ff[AW];
   assign sts.started    = started_ff;
   assign sts.empty      = (depth_ff == '0);
   assign sts.exhausted  = tried_ff[2];
   assign sts.nb_ok      = inb_ff && !vis_rd_ff;

   logic [AW-1:0] top_a;
   assign top_a = AW'(depth_ff - 1'b1);

   logic [6:0] sxf, syf;
   assign sxf = ({1'b0, sx_ff} < ew) ? {1'b0, sx_ff} : ew - 7'd1;
   assign syf = ({1'b0, sy_ff} < eh) ? {1'b0, sy_ff} : eh - 7'd1;

   logic [1:0] dsel;
   assign dsel = order_dir(tp_ff, tried_ff[1:0]);
   logic [6:0] cx1, cy1;
   assign cx1 = {1'b0, tx_ff} + 7'd1;
   assign cy1 = {1'b0, ty_ff} + 7'd1;
   logic ok_c;
   logic [XW-1:0] nx_c;
   logic [YW-1:0] ny_c;
   always_comb begin
      nx_c = tx_ff; ny_c = ty_ff; ok_c = 1'b0;
      case (dir_type'(dsel))
         DIR_N: begin ok_c = (ty_ff != '0); ny_c = ty_ff - 1'b1; end
         DIR_E: begin ok_c = (cx1 < ew);    nx_c = tx_ff + 1'b1; end
         DIR_S: begin ok_c = (cy1 < eh);    ny_c = ty_ff + 1'b1; end
         DIR_W: begin ok_c = (tx_ff != '0); nx_c = tx_ff - 1'b1; end
         default: ;
      endcase
      ok_c = ok_c && ({1'b0, nx_c} < ew) && ({1'b0, ny_c} < eh);
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) visit_mem[clr_ff[AW-1:0]] <= 1'b0;
      else if (cmd.init) visit_mem[{syf[YW-1:0], sxf[XW-1:0]}] <= 1'b1;
      else if (cmd.carve) visit_mem[{ny_ff, nx_ff}] <= 1'b1;
      vis_rd_ff <= visit_mem[{ny_c, nx_c}];
   end

   always_ff @(posedge clock) begin
      if (cmd.init)
         stack_mem[AW'(depth_ff)] <= {sxf[XW-1:0], syf[YW-1:0]};
      else if (cmd.carve && depth_ff < DW'(2**AW))
         stack_mem[AW'(depth_ff)] <= {nx_ff, ny_ff};
      if (cmd.try_dir) tried_mem[top_a] <= tried_ff + 3'd1;
      else if (cmd.init || cmd.carve) tried_mem[AW'(depth_ff)] <= 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0; started_ff <= 1'b0; depth_ff <= '0; rsp_valid <= 1'b0;
         psel_ff <= 1'b0;
      end else begin
         rsp_valid <= cmd.carve || cmd.emit_done;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (accept) perm_ff <= (perm_index >= 5'd24) ? perm_index - 5'd24 : perm_index;
         if (accept) psel_ff <= 1'b1;
         else if (cmd.load_top) psel_ff <= 1'b0;
         if (cmd.init) begin
            started_ff <= 1'b1;
            depth_ff <= depth_ff + 1'b1;
         end
         if (cmd.pop) depth_ff <= depth_ff - 1'b1;
         if (cmd.carve && depth_ff < DW'(2**AW)) depth_ff <= depth_ff + 1'b1;
      end
   end

   // first top load after a beat takes its perm and stores it; later loads read it back
   always_ff @(posedge clock) begin
      if (cmd.load_top) begin
         {tx_ff, ty_ff} <= stack_mem[top_a];
         tried_ff <= tried_mem[top_a];
         tp_ff <= psel_ff ? perm_ff : perm_mem[top_a];
         if (psel_ff) perm_mem[top_a] <= perm_ff;
      end
      if (cmd.try_dir) begin
         tried_ff <= tried_ff + 3'd1;
         dir_ff <= dsel; nx_ff <= nx_c; ny_ff <= ny_c; inb_ff <= ok_c;
      end
      if (cmd.carve) begin
         rsp_cell_x <= 6'(tx_ff); rsp_cell_y <= 6'(ty_ff);
         rsp_direction <= dir_ff; rsp_done_res <= 1'b0;
      end else if (cmd.emit_done) begin
         rsp_cell_x <= '0; rsp_cell_y <= '0; rsp_direction <= '0; rsp_done_res <= 1'b1;
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(2**AW)) else $error("stack overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> depth_ff != '0) else $error("pop on empty");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      !(cmd.carve && cmd.emit_done)) else $error("two results");
endmodule

/* design/grid_maze_backtracker.sv */
// Top level of the grid maze backtracker: controller plus datapath.
// Depends on gmb_pkg, gmb_ctrl and gmb_datapath.
//  channel  | ports                              | handshake
//  request  | req_perm_index                     | start && !busy
//  result   | rsp_cell_x/y, direction, done_res  | rsp_valid, one cycle
//  config   | csr_write, csr_index, csr_data     | csr_write
// Each item steps through TOP (stack top read), then TRY and CHECK for each direction
// tried (visited-bit read), back to TOP for each popped cell, and CARVE; the first
// beat adds INIT, and a done result ends at TOP with an empty stack.
// After reset a clearing pass over the visited memory runs with busy high.
// The receiver cannot stall; each result shows for one cycle.
module grid_maze_backtracker import gmb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [4:0] req_perm_index,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data,
   output logic       rsp_valid,
   output logic [5:0] rsp_cell_x,
   output logic [5:0] rsp_cell_y,
   output logic [1:0] rsp_direction,
   output logic       rsp_done_res
);
   cmd_type cmd;
   sts_type sts;

   gmb_ctrl u_ctrl (.clock, .reset, .start, .busy, .sts, .cmd);

   gmb_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .accept(start && !busy), .perm_index(req_perm_index),
      .cfg_we(csr_write), .cfg_index(csr_index), .cfg_data(csr_data),
      .rsp_valid, .rsp_cell_x, .rsp_cell_y, .rsp_direction, .rsp_done_res
   );
endmodule

/* verif/grid_maze_backtracker_tb.sv */
// Self-checking testbench for grid_maze_backtracker: drives permutation beats,
// predicts every carve or done result and compares it field by field.
// Depends on gmb_pkg and the grid_maze_backtracker RTL.
module grid_maze_backtracker_tb import gmb_pkg::*; ();

   localparam int CellCount = MaxWidth * MaxHeight;
   localparam logic [4:0] VISITED     = 5'h10;

   typedef struct packed {
      logic [5:0] cell_x;
      logic [5:0] cell_y;
      dir_type    direction;
      logic       done_res;
   } carve_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [4:0] req_perm_index;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [6:0] csr_data;
   logic       rsp_valid;
   logic [5:0] rsp_cell_x;
   logic [5:0] rsp_cell_y;
   logic [1:0] rsp_direction;
   logic       rsp_done_res;

   grid_maze_backtracker u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_perm_index(req_perm_index),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_cell_x(rsp_cell_x), .rsp_cell_y(rsp_cell_y),
      .rsp_direction(rsp_direction), .rsp_done_res(rsp_done_res)
   );

   // direction orderings, lexicographic over (N,E,S,W)
   dir_type walk_order [24][4];

   logic [6:0]  cols_reg, rows_reg;
   logic [5:0]  sx_reg, sy_reg;
   logic [4:0]  cell_walls [CellCount];
   logic [5:0]  trail_x [CellCount];
   logic [5:0]  trail_y [CellCount];
   logic [4:0]  trail_perm [CellCount];
   logic [2:0]  trail_tried [CellCount];
   int          trail_depth;
   bit          maze_begun;

   carve_type   pending_carves [$];
   int          mismatches;
   bit          allow_gaps;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void queue_carve(input carve_type c);
      pending_carves = {pending_carves, c};
   endfunction

   function automatic int eff_cols();
      if (cols_reg == 0) return 1;
      return cols_reg > MaxWidth ? MaxWidth : int'(cols_reg);
   endfunction

   function automatic int eff_rows();
      if (rows_reg == 0) return 1;
      return rows_reg > MaxHeight ? MaxHeight : int'(rows_reg);
   endfunction

   function automatic carve_type carve_next(input logic [4:0] perm_in);
      int w, h, cx, cy, nx, ny, px, py, top;
      int perm;
      dir_type d;
      bit ok;
      carve_type res;
      w = eff_cols();
      h = eff_rows();
      perm = perm_in >= 24 ? perm_in - 24 : perm_in;
      if (!maze_begun) begin
         px = sx_reg < w ? sx_reg : w - 1;
         py = sy_reg < h ? sy_reg : h - 1;
         maze_begun = 1'b1;
         cell_walls[py * MaxWidth + px] |= VISITED;
         trail_x[0] = 6'(px);
         trail_y[0] = 6'(py);
         trail_perm[0] = 5'(perm);
         trail_tried[0] = 3'd0;
         trail_depth = 1;
      end else if (trail_depth > 0) begin
         trail_perm[trail_depth - 1] = 5'(perm);
      end
      while (trail_depth > 0) begin
         top = trail_depth - 1;
         if (trail_tried[top] >= 4) begin
            trail_depth--;
            continue;
         end
         cx = trail_x[top];
         cy = trail_y[top];
         d = walk_order[trail_perm[top]][trail_tried[top][1:0]];
         trail_tried[top]++;
         nx = cx;
         ny = cy;
         ok = 1'b0;
         case (d)
            DIR_N: if (cy > 0) begin ny = cy - 1; ok = 1'b1; end
            DIR_E: if (cx + 1 < w) begin nx = cx + 1; ok = 1'b1; end
            DIR_S: if (cy + 1 < h) begin ny = cy + 1; ok = 1'b1; end
            default: if (cx > 0) begin nx = cx - 1; ok = 1'b1; end
         endcase
         if (ok && ny < h && nx < w && !cell_walls[ny * MaxWidth + nx][4]) begin
            cell_walls[cy * MaxWidth + cx][d] = 1'b0;
            cell_walls[ny * MaxWidth + nx][d ^ 2'd2] = 1'b0;
            cell_walls[ny * MaxWidth + nx] |= VISITED;
            if (trail_depth < CellCount) begin
               trail_x[trail_depth] = 6'(nx);
               trail_y[trail_depth] = 6'(ny);
               trail_perm[trail_depth] = 5'd0;
               trail_tried[trail_depth] = 3'd0;
               trail_depth++;
            end
            res.cell_x = 6'(cx);
            res.cell_y = 6'(cy);
            res.direction = d;
            res.done_res = 1'b0;
            return res;
         end
      end
      res = '0;
      res.done_res = 1'b1;
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   always @(posedge clock) begin
      carve_type want;
      if (!reset && rsp_valid) begin
         if (pending_carves.size() == 0) begin
            flag_mismatch("unexpected beat", 1, 0);
         end else begin
            want = pending_carves.pop_front();
            if (rsp_done_res !== want.done_res)
               flag_mismatch("done_res", rsp_done_res, want.done_res);
            if (rsp_cell_x !== want.cell_x) flag_mismatch("cell_x", rsp_cell_x, want.cell_x);
            if (rsp_cell_y !== want.cell_y) flag_mismatch("cell_y", rsp_cell_y, want.cell_y);
            if (rsp_direction !== want.direction)
               flag_mismatch("direction", rsp_direction, want.direction);
         end
      end
   end

   // caller is at a falling edge; returns just after the accepting rising edge
   task automatic send_perm(input logic [4:0] perm);
      int gap;
      @(negedge clock);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_perm_index = perm;
      while (busy) @(negedge clock);
      @(posedge clock);
      queue_carve(carve_next(perm));
   endtask

   task automatic hold_start_low();
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [6:0] val);
      hold_start_low();
      while (busy || pending_carves.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      while (busy) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      case (idx)
         CSR_WIDTH:   cols_reg = val;
         CSR_HEIGHT:  rows_reg = val;
         CSR_START_X: sx_reg = val[5:0];
         default:     sy_reg = val[5:0];
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic test_directed_small_grid();
      write_csr(CSR_WIDTH, 7'd8);
      write_csr(CSR_HEIGHT, 7'd6);
      write_csr(CSR_START_X, 7'd127);
      write_csr(CSR_START_Y, 7'd63);
      for (int p = 31; p >= 24; p--) send_perm(5'(p));
      for (int p = 0; p < 24; p += 2) send_perm(5'(p));
      send_perm(5'd23);
      send_perm(5'd0);
   endtask

   task automatic test_grow_full_width();
      write_csr(CSR_WIDTH, 7'd127);
      write_csr(CSR_HEIGHT, 7'd64);
      write_csr(CSR_START_X, 7'd0);
      write_csr(CSR_START_Y, 7'd0);
      repeat (320) send_perm(5'($urandom_range(0, 31)));
   endtask

   task automatic test_reshape_tall();
      write_csr(CSR_WIDTH, 7'd40);
      write_csr(CSR_HEIGHT, 7'd127);
      repeat (300) send_perm(5'($urandom_range(0, 31)));
   endtask

   task automatic test_collapse_to_done();
      allow_gaps = 1'b0;
      write_csr(CSR_WIDTH, 7'd0);
      write_csr(CSR_HEIGHT, 7'd0);
      repeat (40) send_perm(5'($urandom_range(0, 31)));
      write_csr(CSR_WIDTH, 7'd1);
      write_csr(CSR_HEIGHT, 7'd1);
      repeat (20) send_perm(5'($urandom_range(0, 31)));
   endtask

   initial begin
      int n;
      clock = 1'b0;
      n = 0;
      for (int a = 0; a < 4; a++)
         for (int b = 0; b < 4; b++)
            for (int c = 0; c < 4; c++)
               if (a != b && a != c && b != c) begin
                  walk_order[n][0] = dir_type'(a);
                  walk_order[n][1] = dir_type'(b);
                  walk_order[n][2] = dir_type'(c);
                  walk_order[n][3] = dir_type'(6 - a - b - c);
                  n++;
               end
      cols_reg = 7'd16;
      rows_reg = 7'd16;
      sx_reg = '0;
      sy_reg = '0;
      for (int i = 0; i < CellCount; i++) cell_walls[i] = 5'h0F;
      trail_depth = 0;
      maze_begun = 1'b0;
      mismatches = 0;
      allow_gaps = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_perm_index = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_directed_small_grid();
      test_grow_full_width();
      test_reshape_tall();
      test_collapse_to_done();
      hold_start_low();
      while (pending_carves.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatches == 0 && pending_carves.size() == 0)
         $display("grid_maze_backtracker regression: pass");
      else
         $display("grid_maze_backtracker regression: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("grid_maze_backtracker regression: fail");
      $finish;
   end
endmodule
